[rtl/hrp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the HTTP request parser.
// No dependencies; used by rtl/http_request_parser.sv.

package hrp_pkg;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Field kinds
    localparam logic [2:0] K_METHOD  = 3'd0;
    localparam logic [2:0] K_PATH    = 3'd1;
    localparam logic [2:0] K_VERSION = 3'd2;
    localparam logic [2:0] K_KEY     = 3'd3;
    localparam logic [2:0] K_VALUE   = 3'd4;
    localparam logic [2:0] K_BODY    = 3'd5;

    // Result types
    localparam logic [1:0] R_DATA   = 2'd0;
    localparam logic [1:0] R_END    = 2'd1;
    localparam logic [1:0] R_ACCEPT = 2'd2;
    localparam logic [1:0] R_REJECT = 2'd3;

    // Parse position within the message
    typedef enum logic [3:0] {
        PH_METHOD     = 4'd0,
        PH_PATH       = 4'd1,
        PH_VERSION    = 4'd2,
        PH_FIRST_KEY  = 4'd3,
        PH_KEY_START  = 4'd4,
        PH_KEY        = 4'd5,
        PH_VALUE_LEAD = 4'd6,
        PH_VALUE      = 4'd7,
        PH_BODY       = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic [1:0] result_type;
        logic       last_result;
    } out_item_t;

    // One optional result, a reject flag and the phase it leaves behind
    typedef struct packed {
        logic      en;
        logic      rej;
        out_item_t res;
        phase_t    ph;
    } step_t;

endpackage

[rtl/http_request_parser.sv]
`timescale 1ns / 1ps
// HTTP/1.1 request parser: byte-wise field splitter with accept/reject status.
// Depends on rtl/hrp_pkg.sv.
//
//  Channel   | Handshake                     | Payload
//  ----------+-------------------------------+--------------------------------
//  request   | byte_valid in, byte_stall out | byte_item   (hrp_pkg::in_item_t)
//  result    | result_valid out, result_stall| result_item (hrp_pkg::out_item_t)
//
//  Each accepted byte is decoded in the cycle it is taken; its results (0..3)
//  land in a three-slot result register, drained one per cycle unless stalled.
//  A byte that gives at most one result sustains one byte per cycle when
//  unstalled; a byte giving more results holds the input until they drain.
//  A new byte is taken in the same cycle as the last pending result leaves.
//  rst_n (async, low) returns the parser to the method field with no results
//  pending. result_stall holds the result register and so stalls the input.

module http_request_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  hrp_pkg::in_item_t   byte_item,
    output logic                result_valid,
    input  logic                result_stall,
    output hrp_pkg::out_item_t  result_item
);

    // Parser state
    hrp_pkg::phase_t phase_reg, phase_next;
    logic            cr_pending_reg, cr_pending_next;
    logic            rejected_reg, rejected_next;

    // Result register: up to three results per byte, drained by idx_reg
    hrp_pkg::out_item_t res_reg [3];
    hrp_pkg::out_item_t res_next [3];
    logic [1:0]         cnt_reg, cnt_next;
    logic [1:0]         idx_reg;

    logic accept;
    logic drain;
    logic last_leaving;

    // ------------------------------------------------------------------
    // Per-byte helpers
    // ------------------------------------------------------------------
    function automatic hrp_pkg::out_item_t mk(logic [7:0] b, logic [2:0] k, logic [1:0] t);
        hrp_pkg::out_item_t r;
        r.out_byte    = b;
        r.kind        = k;
        r.result_type = t;
        r.last_result = 1'b0;
        return r;
    endfunction

    // A byte that does not end a line (lone CR included)
    function automatic hrp_pkg::step_t data_byte(hrp_pkg::phase_t ph, logic [7:0] c);
        hrp_pkg::step_t s;
        s.en  = 1'b1;
        s.rej = 1'b0;
        s.ph  = ph;
        s.res = mk(c, hrp_pkg::K_METHOD, hrp_pkg::R_DATA);
        unique case (ph)
            hrp_pkg::PH_METHOD:
            begin
                if (c == hrp_pkg::CH_SPACE)
                begin
                    s.res = mk(8'h00, hrp_pkg::K_METHOD, hrp_pkg::R_END);
                    s.ph  = hrp_pkg::PH_PATH;
                end
            end
            hrp_pkg::PH_PATH:
            begin
                if (c == hrp_pkg::CH_SPACE)
                begin
                    s.res = mk(8'h00, hrp_pkg::K_PATH, hrp_pkg::R_END);
                    s.ph  = hrp_pkg::PH_VERSION;
                end
                else
                begin
                    s.res = mk(c, hrp_pkg::K_PATH, hrp_pkg::R_DATA);
                end
            end
            hrp_pkg::PH_VERSION:
            begin
                s.res = mk(c, hrp_pkg::K_VERSION, hrp_pkg::R_DATA);
            end
            hrp_pkg::PH_FIRST_KEY, hrp_pkg::PH_KEY_START, hrp_pkg::PH_KEY:
            begin
                if (c == hrp_pkg::CH_COLON)
                begin
                    s.res = mk(8'h00, hrp_pkg::K_KEY, hrp_pkg::R_END);
                    s.ph  = hrp_pkg::PH_VALUE_LEAD;
                end
                else
                begin
                    if (c >= hrp_pkg::CH_UPPER_A && c <= hrp_pkg::CH_UPPER_Z)
                        s.res = mk(c + hrp_pkg::CASE_OFFSET, hrp_pkg::K_KEY,
                                   hrp_pkg::R_DATA);
                    else
                        s.res = mk(c, hrp_pkg::K_KEY, hrp_pkg::R_DATA);
                    s.ph = hrp_pkg::PH_KEY;
                end
            end
            hrp_pkg::PH_VALUE_LEAD:
            begin
                // leading spaces of a value are dropped
                s.res = mk(c, hrp_pkg::K_VALUE, hrp_pkg::R_DATA);
                if (c == hrp_pkg::CH_SPACE)
                    s.en = 1'b0;
                else
                    s.ph = hrp_pkg::PH_VALUE;
            end
            hrp_pkg::PH_VALUE:
            begin
                s.res = mk(c, hrp_pkg::K_VALUE, hrp_pkg::R_DATA);
            end
            default:
            begin
                s.en = 1'b0;
            end
        endcase
        return s;
    endfunction

    // CRLF outside the body
    function automatic hrp_pkg::step_t line_end(hrp_pkg::phase_t ph);
        hrp_pkg::step_t s;
        s.en  = 1'b1;
        s.rej = 1'b0;
        s.ph  = ph;
        s.res = mk(8'h00, hrp_pkg::K_METHOD, hrp_pkg::R_REJECT);
        unique case (ph)
            hrp_pkg::PH_VERSION:
            begin
                s.res = mk(8'h00, hrp_pkg::K_VERSION, hrp_pkg::R_END);
                s.ph  = hrp_pkg::PH_FIRST_KEY;
            end
            hrp_pkg::PH_KEY_START:
            begin
                // empty line closes the headers
                s.en = 1'b0;
                s.ph = hrp_pkg::PH_BODY;
            end
            hrp_pkg::PH_VALUE:
            begin
                s.res = mk(8'h00, hrp_pkg::K_VALUE, hrp_pkg::R_END);
                s.ph  = hrp_pkg::PH_KEY_START;
            end
            default:
            begin
                // short request line, key without colon, empty value,
                // or no header lines at all
                s.rej = 1'b1;
            end
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Decode of the byte at the input
    // ------------------------------------------------------------------
    always_comb
    begin
        hrp_pkg::step_t s;
        logic [7:0]     b;
        logic           fin;
        logic [1:0]     n;

        s   = '0;
        b   = byte_item.in_byte;
        fin = byte_item.final_byte;
        n   = 2'd0;
        phase_next      = phase_reg;
        cr_pending_next = cr_pending_reg;
        rejected_next   = rejected_reg;
        for (int i = 0; i < 3; i++)
            res_next[i] = mk(8'h00, hrp_pkg::K_METHOD, hrp_pkg::R_DATA);

        if (!rejected_reg)
        begin
            if (phase_reg == hrp_pkg::PH_BODY)
            begin
                res_next[n] = mk(b, hrp_pkg::K_BODY, hrp_pkg::R_DATA);
                n = n + 2'd1;
            end
            else
            begin
                if (cr_pending_reg)
                begin
                    cr_pending_next = 1'b0;
                    if (b == hrp_pkg::CH_LF)
                    begin
                        s = line_end(phase_next);
                        if (s.en)
                        begin
                            res_next[n] = s.res;
                            n = n + 2'd1;
                        end
                        phase_next    = s.ph;
                        rejected_next = s.rej;
                    end
                    else
                    begin
                        // held CR was an ordinary byte
                        s = data_byte(phase_next, hrp_pkg::CH_CR);
                        if (s.en)
                        begin
                            res_next[n] = s.res;
                            n = n + 2'd1;
                        end
                        phase_next = s.ph;
                    end
                end
                if (!(cr_pending_reg && b == hrp_pkg::CH_LF))
                begin
                    if (b == hrp_pkg::CH_CR)
                    begin
                        cr_pending_next = 1'b1;
                    end
                    else
                    begin
                        s = data_byte(phase_next, b);
                        if (s.en)
                        begin
                            res_next[n] = s.res;
                            n = n + 2'd1;
                        end
                        phase_next = s.ph;
                    end
                end
            end

            if (fin && !rejected_next)
            begin
                if (phase_next == hrp_pkg::PH_BODY)
                begin
                    res_next[n] = mk(8'h00, hrp_pkg::K_BODY, hrp_pkg::R_END);
                    n = n + 2'd1;
                    res_next[n] = mk(8'h00, hrp_pkg::K_METHOD, hrp_pkg::R_ACCEPT);
                    n = n + 2'd1;
                end
                else
                begin
                    // message ended before the body began
                    res_next[n] = mk(8'h00, hrp_pkg::K_METHOD, hrp_pkg::R_REJECT);
                    n = n + 2'd1;
                end
            end
        end

        if (n != 2'd0)
            res_next[n - 2'd1].last_result = 1'b1;
        cnt_next = n;

        // every message starts from a clean state
        if (fin)
        begin
            phase_next      = hrp_pkg::PH_METHOD;
            cr_pending_next = 1'b0;
            rejected_next   = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign result_valid = (idx_reg != cnt_reg);
    assign drain        = result_valid && !result_stall;
    assign last_leaving = drain && (idx_reg + 2'd1 == cnt_reg);
    assign byte_stall   = result_valid && !last_leaving;
    assign accept       = byte_valid && !byte_stall;

    always_comb
    begin
        case (idx_reg)
            2'd0:    result_item = res_reg[0];
            2'd1:    result_item = res_reg[1];
            default: result_item = res_reg[2];
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= hrp_pkg::PH_METHOD;
            cr_pending_reg <= 1'b0;
            rejected_reg   <= 1'b0;
            cnt_reg        <= 2'd0;
            idx_reg        <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            cr_pending_reg <= cr_pending_next;
            rejected_reg   <= rejected_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= 2'd0;
        end
        else if (drain)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
                res_reg[i] <= res_next[i];
        end
    end

endmodule

[tb/http_request_parser_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for http_request_parser: byte streams in, field results out.
// Depends on rtl/hrp_pkg.sv and rtl/http_request_parser.sv.

module http_request_parser_test;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 12;    // quiet cycles after the last result
    localparam int PHASE_BYTES  = 20;    // minimum random bytes per idling phase

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               byte_valid = 1'b0;
    logic               byte_stall;
    hrp_pkg::in_item_t  byte_item = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    hrp_pkg::out_item_t result_item;

    http_request_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bytes waiting to be offered, and field results the parser still owes.
    hrp_pkg::in_item_t  request_bytes[$];
    hrp_pkg::out_item_t field_results[$];

    int bytes_queued   = 0;
    int mismatches     = 0;
    int cycles         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;

    // ------------------------------------------------------------------
    // Parser model: own copy of the parse position and flags.
    // ------------------------------------------------------------------
    hrp_pkg::phase_t    ph = hrp_pkg::PH_METHOD;
    logic               cr_held = 1'b0;
    logic               refused = 1'b0;
    hrp_pkg::out_item_t step_res[3];
    int                 nres;

    function automatic void add_res(logic [7:0] b, logic [2:0] k, logic [1:0] t);
        if (nres < 3)
        begin
            step_res[nres] = '{out_byte: b, kind: k, result_type: t, last_result: 1'b0};
            nres++;
        end
    endfunction

    function automatic void refuse();
        add_res(8'h00, hrp_pkg::K_METHOD, hrp_pkg::R_REJECT);
        refused = 1'b1;
    endfunction

    // A byte that does not end a line; a lone CR comes through here too.
    function automatic void field_byte(logic [7:0] c);
        case (ph)
            hrp_pkg::PH_METHOD:
                if (c == hrp_pkg::CH_SPACE)
                begin
                    add_res(8'h00, hrp_pkg::K_METHOD, hrp_pkg::R_END);
                    ph = hrp_pkg::PH_PATH;
                end
                else
                    add_res(c, hrp_pkg::K_METHOD, hrp_pkg::R_DATA);
            hrp_pkg::PH_PATH:
                if (c == hrp_pkg::CH_SPACE)
                begin
                    add_res(8'h00, hrp_pkg::K_PATH, hrp_pkg::R_END);
                    ph = hrp_pkg::PH_VERSION;
                end
                else
                    add_res(c, hrp_pkg::K_PATH, hrp_pkg::R_DATA);
            hrp_pkg::PH_VERSION:
                add_res(c, hrp_pkg::K_VERSION, hrp_pkg::R_DATA);
            hrp_pkg::PH_FIRST_KEY, hrp_pkg::PH_KEY_START, hrp_pkg::PH_KEY:
                if (c == hrp_pkg::CH_COLON)
                begin
                    add_res(8'h00, hrp_pkg::K_KEY, hrp_pkg::R_END);
                    ph = hrp_pkg::PH_VALUE_LEAD;
                end
                else
                begin
                    add_res((c >= hrp_pkg::CH_UPPER_A && c <= hrp_pkg::CH_UPPER_Z) ?
                            c + hrp_pkg::CASE_OFFSET : c,
                            hrp_pkg::K_KEY, hrp_pkg::R_DATA);
                    ph = hrp_pkg::PH_KEY;
                end
            hrp_pkg::PH_VALUE_LEAD:
                if (c != hrp_pkg::CH_SPACE)
                begin
                    add_res(c, hrp_pkg::K_VALUE, hrp_pkg::R_DATA);
                    ph = hrp_pkg::PH_VALUE;
                end
            hrp_pkg::PH_VALUE:
                add_res(c, hrp_pkg::K_VALUE, hrp_pkg::R_DATA);
            default:
                ;
        endcase
    endfunction

    // CRLF outside the body.
    function automatic void line_done();
        case (ph)
            hrp_pkg::PH_VERSION:
            begin
                add_res(8'h00, hrp_pkg::K_VERSION, hrp_pkg::R_END);
                ph = hrp_pkg::PH_FIRST_KEY;
            end
            hrp_pkg::PH_KEY_START:
                ph = hrp_pkg::PH_BODY;
            hrp_pkg::PH_VALUE:
            begin
                add_res(8'h00, hrp_pkg::K_VALUE, hrp_pkg::R_END);
                ph = hrp_pkg::PH_KEY_START;
            end
            default:
                refuse();
        endcase
    endfunction

    function automatic void take_plain(logic [7:0] c);
        if (c == hrp_pkg::CH_CR)
            cr_held = 1'b1;
        else
            field_byte(c);
    endfunction

    // Work out the results of one accepted byte and queue them.
    function automatic void parse_byte(hrp_pkg::in_item_t it);
        hrp_pkg::out_item_t r;
        nres = 0;
        if (!refused)
        begin
            if (ph == hrp_pkg::PH_BODY)
                add_res(it.in_byte, hrp_pkg::K_BODY, hrp_pkg::R_DATA);
            else if (cr_held)
            begin
                cr_held = 1'b0;
                if (it.in_byte == hrp_pkg::CH_LF)
                    line_done();
                else
                begin
                    field_byte(hrp_pkg::CH_CR);
                    take_plain(it.in_byte);
                end
            end
            else
                take_plain(it.in_byte);
            if (it.final_byte && !refused)
            begin
                if (ph == hrp_pkg::PH_BODY)
                begin
                    add_res(8'h00, hrp_pkg::K_BODY, hrp_pkg::R_END);
                    add_res(8'h00, hrp_pkg::K_METHOD, hrp_pkg::R_ACCEPT);
                end
                else
                    refuse();
            end
        end
        if (it.final_byte)
        begin
            ph      = hrp_pkg::PH_METHOD;
            cr_held = 1'b0;
            refused = 1'b0;
        end
        for (int i = 0; i < nres; i++)
        begin
            r = step_res[i];
            r.last_result = (i == nres - 1);
            field_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued bytes, holds a stalled item steady.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!byte_valid || !byte_stall)
            begin
                if (request_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_item  <= request_bytes.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // Long hold-off, counted down on its own.
    always @(posedge clk)
    begin
        if (hold_ack != hold_req)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin
        result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on accepted bytes first, then checks the result
    // taken at the same edge, so ordering between blocks does not matter.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        hrp_pkg::out_item_t want;
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                parse_byte(byte_item);
            if (result_valid && !result_stall)
            begin
                if (field_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("cycle %0d: unexpected result byte %h kind %0d type %0d last %b",
                                 cycles, result_item.out_byte, result_item.kind,
                                 result_item.result_type, result_item.last_result);
                    mismatches++;
                end
                else
                begin
                    want = field_results.pop_front();
                    if (result_item.out_byte !== want.out_byte ||
                        result_item.kind !== want.kind ||
                        result_item.result_type !== want.result_type ||
                        result_item.last_result !== want.last_result)
                    begin
                        if (mismatches < 10)
                            $display("cycle %0d: expected byte %h kind %0d type %0d last %b, %s",
                                     cycles, want.out_byte, want.kind, want.result_type,
                                     want.last_result, "got:");
                        if (mismatches < 10)
                            $display("    got byte %h kind %0d type %0d last %b",
                                     result_item.out_byte, result_item.kind,
                                     result_item.result_type, result_item.last_result);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic put(logic [7:0] b, logic fin);
        request_bytes.push_back('{in_byte: b, final_byte: fin});
        bytes_queued++;
    endtask

    // '@'..DEL: never space, colon, CR or LF; covers both ends of A-Z.
    function automatic logic [7:0] token_char();
        return 8'h40 + 8'($urandom_range(0, 63));
    endfunction

    // One request with random content; damaged ones get a byte replaced,
    // dropped, or the message cut short.
    task automatic queue_message(bit damaged);
        logic [7:0] msg[$];
        int n;
        int nh;
        int pos;
        int cut;
        n = $urandom_range(0, 4);
        repeat (n) msg.push_back(token_char());
        msg.push_back(hrp_pkg::CH_SPACE);
        msg.push_back(8'h2F);
        n = $urandom_range(0, 5);
        repeat (n) msg.push_back(token_char());
        msg.push_back(hrp_pkg::CH_SPACE);
        n = $urandom_range(0, 6);
        repeat (n) msg.push_back(token_char());
        msg.push_back(hrp_pkg::CH_CR);
        msg.push_back(hrp_pkg::CH_LF);
        nh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        repeat (nh)
        begin
            n = $urandom_range(0, 5);
            repeat (n) msg.push_back(token_char());
            if ($urandom_range(0, 7) == 0)
            begin
                msg.push_back(hrp_pkg::CH_CR);  // lone CR inside the key
                msg.push_back(token_char());
            end
            msg.push_back(hrp_pkg::CH_COLON);
            n = $urandom_range(0, 2);
            repeat (n) msg.push_back(hrp_pkg::CH_SPACE);
            if ($urandom_range(0, 7) == 0)
                msg.push_back(hrp_pkg::CH_CR);  // lone CR opens the value
            msg.push_back(8'h21 + 8'($urandom_range(0, 93)));
            n = $urandom_range(0, 4);
            repeat (n) msg.push_back(8'h20 + 8'($urandom_range(0, 94)));
            msg.push_back(hrp_pkg::CH_CR);
            msg.push_back(hrp_pkg::CH_LF);
        end
        msg.push_back(hrp_pkg::CH_CR);
        msg.push_back(hrp_pkg::CH_LF);
        n = $urandom_range(0, 6);
        repeat (n) msg.push_back(8'($urandom_range(0, 255)));
        if (damaged)
        begin
            pos = $urandom_range(0, msg.size() - 1);
            case ($urandom_range(0, 2))
                0: msg[pos] = 8'($urandom_range(0, 255));
                1: msg.delete(pos);
                default:
                begin
                    cut = $urandom_range(1, msg.size());
                    while (msg.size() > cut)
                        void'(msg.pop_back());
                end
            endcase
        end
        for (int i = 0; i < msg.size(); i++)
            put(msg[i], i == msg.size() - 1);
    endtask

    // Raw bytes with scattered final flags; always ends on a final byte.
    task automatic queue_noise();
        int n;
        n = $urandom_range(4, 16);
        for (int i = 0; i < n; i++)
            put(8'($urandom_range(0, 255)), (i == n - 1) || ($urandom_range(0, 7) == 0));
    endtask

    task automatic wait_drain();
        while (request_bytes.size() != 0 || byte_valid || field_results.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        int mark;
        int pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Accepted message: empty method, path and version; lone CR in the
        // key and as first value byte; upper case key; 0xFF body on final.
        put(hrp_pkg::CH_SPACE, 1'b0);
        put(hrp_pkg::CH_SPACE, 1'b0);
        put(hrp_pkg::CH_CR, 1'b0);
        put(hrp_pkg::CH_LF, 1'b0);
        put(hrp_pkg::CH_CR, 1'b0);
        put(8'h5A, 1'b0);
        put(8'h41, 1'b0);
        put(hrp_pkg::CH_COLON, 1'b0);
        put(hrp_pkg::CH_SPACE, 1'b0);
        put(hrp_pkg::CH_CR, 1'b0);
        put(8'h76, 1'b0);
        put(hrp_pkg::CH_CR, 1'b0);
        put(hrp_pkg::CH_LF, 1'b0);
        put(hrp_pkg::CH_CR, 1'b0);
        put(hrp_pkg::CH_LF, 1'b0);
        put(8'hFF, 1'b1);
        // No header lines at all, then a final byte after the rejection.
        put(hrp_pkg::CH_SPACE, 1'b0);
        put(hrp_pkg::CH_SPACE, 1'b0);
        put(hrp_pkg::CH_CR, 1'b0);
        put(hrp_pkg::CH_LF, 1'b0);
        put(hrp_pkg::CH_CR, 1'b0);
        put(hrp_pkg::CH_LF, 1'b0);
        put(8'h00, 1'b1);
        // Line ends before the second space; final on that same LF.
        put(8'h61, 1'b0);
        put(hrp_pkg::CH_CR, 1'b0);
        put(hrp_pkg::CH_LF, 1'b1);
        // Early end with a CR still held back.
        put(8'h47, 1'b0);
        put(hrp_pkg::CH_CR, 1'b1);
        wait_drain();

        // Random part under each idling pattern.
        for (int m = 0; m < 4; m++)
        begin
            case (m)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            mark = bytes_queued;
            while (bytes_queued - mark < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    queue_message(1'b0);
                else if (pick < 85)
                    queue_message(1'b1);
                else
                    queue_noise();
            end
            wait_drain();
        end

        // Back pressure: receiver holds off while the sender keeps offering.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_message(1'b0);
        queue_message(1'b1);
        hold_req = hold_req + 1;
        wait_drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && field_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
